/* src/sparse_block_height_map_assert.svh */
// Assertion macros shared by the height map RTL.
// No dependencies; included inside module bodies.
`ifndef SPARSE_BLOCK_HEIGHT_MAP_ASSERT_SVH
`define SPARSE_BLOCK_HEIGHT_MAP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SBHM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbhm assertion failed");

// Next-cycle implication checked outside reset.
`define SBHM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbhm assertion failed");

`endif

/* src/sbhm_pkg.sv */
// Shared types and constants of the sparse block height map.
// No dependencies.
`default_nettype none
package sbhm_pkg;
  localparam logic [2:0] CMD_SET   = 3'd0;
  localparam logic [2:0] CMD_RAISE = 3'd1;
  localparam logic [2:0] CMD_LOWER = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam int STAMP_W = 8;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [STAMP_W-1:0] STAMP_FIRST = 8'd1;
  localparam logic [7:0] CONF_CAP = 8'd4;
  localparam logic signed [16:0] FUSE_MARGIN_MM = 17'sd1000;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [7:0]         conf;
    logic signed [15:0] height;
  } cell_word_t;

  typedef struct packed {
    logic found;
    logic full;
  } slot_look_t;
endpackage
`default_nettype wire

/* src/sbhm_slot_tab.sv */
// Block key table: key flops, registered parallel match, in-order allocation.
// Depends on sbhm_pkg.
`default_nettype none
module sbhm_slot_tab #(
  parameter int NUM_SLOTS = 64,
  parameter int SLOT_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [31:0]       key,
  input  wire logic              lookup,
  input  wire logic              alloc_en,
  input  wire logic              clear_en,
  output sbhm_pkg::slot_look_t   look,
  output logic [SLOT_W-1:0]      hit_slot,
  output logic [SLOT_W-1:0]      alloc_slot
);
  import sbhm_pkg::*;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [31:0]          keys_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] match_r, match_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_nxt[i] = valid_r[i] && (keys_r[i] == key);
    end
  end

  // Keys never repeat, so the match vector is one-hot or empty: OR the hits.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_slot = hit_slot | (SLOT_W'(i) & {SLOT_W{match_r[i]}});
    end
  end

  assign look.found = |match_r;
  assign look.full  = (used_r >= CNT_W'(NUM_SLOTS));
  assign alloc_slot = used_r[SLOT_W-1:0];

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (clear_en) begin
      valid_nxt = '0;
      used_nxt  = '0;
    end else if (alloc_en) begin
      valid_nxt[alloc_slot] = 1'b1;
      used_nxt = used_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      match_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      if (lookup) begin
        match_r <= match_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_en && !clear_en) begin
      keys_r[alloc_slot] <= key;
    end
  end
endmodule
`default_nettype wire

/* src/sbhm_cell_ram.sv */
// Cell memory: one write port, one registered read port, stamp-clearing sweep.
// Depends on sbhm_pkg.
`default_nettype none
module sbhm_cell_ram #(
  parameter int DEPTH = 65536,
  parameter int ADDR_W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output sbhm_pkg::cell_word_t      rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  sbhm_pkg::cell_word_t      wr_data,
  input  wire logic                 sweep_start,
  output logic                      busy
);
  import sbhm_pkg::*;

  cell_word_t        mem [DEPTH];
  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;

  assign busy = busy_r;

  always_comb begin
    busy_nxt  = busy_r;
    sweep_nxt = sweep_r;
    if (sweep_start) begin
      busy_nxt  = 1'b1;
      sweep_nxt = '0;
    end else if (busy_r) begin
      if (sweep_r == ADDR_W'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        sweep_nxt = sweep_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      sweep_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[sweep_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* src/sparse_block_height_map.sv */
// Sparse block height map. Each beat carries one command (set, raise fuse,
// lower fuse, read, clear all) and yields exactly one result beat. A command
// passes through accept, key match against all slot keys (registered),
// cell memory read, then fuse and write back. One command is in flight at a
// time; the next beat is taken while the previous result still waits on the
// output register. Cell words carry a clear stamp: a cell reads as zero
// unless its stamp equals the current epoch, so allocating a block or
// clearing the table needs no memory pass. After reset, and after a clear
// that wraps the 8-bit epoch, the whole cell memory is swept, and no input
// beat is accepted while the sweep runs. BLOCK_SIZE must be a power of two.
// Depends on sbhm_pkg, sbhm_slot_tab, sbhm_cell_ram and the assertion header.
`default_nettype none
module sparse_block_height_map #(
  parameter int BLOCK_SIZE = 32,
  parameter int NUM_BLOCK_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cell_x[20:0], cell_y[41:21], height_mm[57:42], set_confidence[65:58], zero pad
  input  wire logic [71:0] in_tdata,
  // command[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cell_height[15:0], cell_confidence[23:16]
  output logic [23:0]      out_tdata,
  // block_found[0], table_full[1]
  output logic [1:0]       out_tuser
);
  import sbhm_pkg::*;
  `include "sparse_block_height_map_assert.svh"

  localparam int BS_W   = $clog2(BLOCK_SIZE);
  localparam int SLOT_W = (NUM_BLOCK_SLOTS > 1) ? $clog2(NUM_BLOCK_SLOTS) : 1;
  localparam int OFF_W  = 2 * BS_W;
  localparam int ADDR_W = SLOT_W + OFF_W;
  localparam int DEPTH  = NUM_BLOCK_SLOTS * BLOCK_SIZE * BLOCK_SIZE;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WB    = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Command held for its whole trip.
  logic [2:0]         cmd_r;
  logic signed [20:0] x_r, y_r;
  logic signed [15:0] h_r;
  logic [7:0]         sc_r;

  logic [STAMP_W-1:0] epoch_r, epoch_nxt;

  logic               out_valid_r;
  logic signed [15:0] out_h_r;
  logic [7:0]         out_c_r;
  logic               out_found_r, out_full_r;

  slot_look_t          look, look_r;
  logic [SLOT_W-1:0]   hit_slot, alloc_slot, slot_r;
  logic [31:0]         key;
  logic [OFF_W-1:0]    off;
  logic signed [20:0]  bx, by;

  cell_word_t  rd_word, wr_word;
  logic        ram_busy, sweep_start, wr_en, alloc_en, clear_en;
  logic [ADDR_W-1:0] wr_addr;

  logic               in_hs, wb_go;
  logic               cur_live, do_write;
  logic signed [15:0] cur_h, new_h;
  logic [7:0]         cur_c, new_c;
  logic signed [16:0] lower_lim;

  assign in_tready = (state_r == ST_IDLE) && !ram_busy;
  assign in_hs = in_tvalid && in_tready;

  // Block coordinate is floor division, i.e. an arithmetic shift.
  assign bx  = x_r >>> BS_W;
  assign by  = y_r >>> BS_W;
  assign key = {bx[15:0], by[15:0]};
  assign off = {x_r[BS_W-1:0], y_r[BS_W-1:0]};

  sbhm_slot_tab #(
    .NUM_SLOTS (NUM_BLOCK_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_slot_tab (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        (key),
    .lookup     (state_r == ST_MATCH),
    .alloc_en   (alloc_en),
    .clear_en   (clear_en),
    .look       (look),
    .hit_slot   (hit_slot),
    .alloc_slot (alloc_slot)
  );

  sbhm_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (state_r == ST_READ),
    .rd_addr     ({hit_slot, off}),
    .rd_data     (rd_word),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_word),
    .sweep_start (sweep_start),
    .busy        (ram_busy)
  );

  // A cell whose stamp is stale belongs to an earlier epoch: read zero.
  assign cur_live = look_r.found && (rd_word.stamp == epoch_r);
  assign cur_h = cur_live ? rd_word.height : 16'sd0;
  assign cur_c = cur_live ? rd_word.conf : 8'd0;
  assign lower_lim = 17'(cur_h) + FUSE_MARGIN_MM;

  always_comb begin
    new_h = cur_h;
    new_c = cur_c;
    do_write = 1'b0;
    unique case (cmd_r)
      CMD_SET: begin
        new_h = h_r;
        new_c = sc_r;
        do_write = 1'b1;
      end
      CMD_RAISE: begin
        do_write = 1'b1;
        if (cur_c == 8'd0) begin
          new_h = h_r;
          new_c = 8'd1;
        end else begin
          new_h = (h_r > cur_h) ? h_r : cur_h;
          new_c = (cur_c >= CONF_CAP - 8'd1) ? CONF_CAP : cur_c + 8'd1;
        end
      end
      CMD_LOWER: begin
        if (cur_c != 8'd0 && lower_lim > 17'(h_r)) begin
          do_write = 1'b1;
          if (cur_c < CONF_CAP) begin
            new_h = h_r;
            new_c = CONF_CAP;
          end else begin
            new_c = cur_c - 8'd1;
          end
        end
      end
      default: begin
        // read, clear and unused codes change no cell
      end
    endcase
  end

  // Hold the write-back while the previous result is not yet taken.
  assign wb_go = (state_r == ST_WB) && !(out_valid_r && !out_tready);

  assign clear_en = wb_go && (cmd_r == CMD_CLEAR);
  assign alloc_en = wb_go && (cmd_r != CMD_CLEAR) && do_write && !look_r.found
                    && !look_r.full;
  assign wr_en    = wb_go && (cmd_r != CMD_CLEAR) && do_write
                    && (look_r.found || !look_r.full);
  assign wr_addr  = {(look_r.found ? slot_r : alloc_slot), off};
  assign wr_word  = '{stamp: epoch_r, conf: new_c, height: new_h};
  assign sweep_start = clear_en && (epoch_r == STAMP_MAX);

  always_comb begin
    epoch_nxt = epoch_r;
    if (clear_en) begin
      epoch_nxt = (epoch_r == STAMP_MAX) ? STAMP_FIRST : epoch_r + STAMP_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_hs) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WB;
      ST_WB:    if (wb_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      epoch_r     <= STAMP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      cmd_r <= in_tuser;
      x_r   <= in_tdata[20:0];
      y_r   <= in_tdata[41:21];
      h_r   <= in_tdata[57:42];
      sc_r  <= in_tdata[65:58];
    end
    if (state_r == ST_READ) begin
      look_r <= look;
      slot_r <= hit_slot;
    end
    if (wb_go) begin
      if (cmd_r == CMD_CLEAR) begin
        out_h_r     <= '0;
        out_c_r     <= '0;
        out_found_r <= 1'b0;
        out_full_r  <= 1'b0;
      end else if (do_write && !look_r.found && look_r.full) begin
        out_h_r     <= '0;
        out_c_r     <= '0;
        out_found_r <= 1'b0;
        out_full_r  <= 1'b1;
      end else begin
        out_h_r     <= new_h;
        out_c_r     <= new_c;
        out_found_r <= look_r.found;
        out_full_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_c_r, out_h_r};
  assign out_tuser  = {out_full_r, out_found_r};

  `SBHM_ASSERT_IMP(a_full_not_found, out_valid_r && out_full_r, !out_found_r && out_h_r == 16'sd0 && out_c_r == 8'd0)
  `SBHM_ASSERT_IMP(a_no_accept_in_sweep, in_hs, !ram_busy)
  `SBHM_ASSERT_NEXT(a_wb_holds, state_r == ST_WB && out_valid_r && !out_tready, state_r == ST_WB)
  `SBHM_ASSERT_IMP(a_write_not_during_sweep, wr_en, !ram_busy)
endmodule
`default_nettype wire

/* tb/sparse_block_height_map_tb.sv */
// Self-checking testbench for sparse_block_height_map: random and directed
// map commands through the stream ports, checked against an in-bench model.
// Depends on sbhm_pkg and the sparse_block_height_map RTL.
`default_nettype none
module sparse_block_height_map_tb;
  import sbhm_pkg::*;

  localparam int BLK_SHIFT = 5;               // BLOCK_SIZE 32
  localparam int SLOTS = 64;
  localparam int CELLS = SLOTS * 1024;
  localparam int IDLE_LIMIT = 200000;         // covers the memory sweep after reset
  localparam int TAIL_CYCLES = 20;
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;  // unused codes behave as read
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic signed [15:0] h;
    logic [7:0]         sc;
    bit                 drain;  // hold this beat until all results are back
  } map_cmd_t;

  typedef struct {
    logic signed [15:0] h;
    logic [7:0]         conf;
    logic               found;
    logic               full;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  sparse_block_height_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  // Map shadow: slot keys, allocation count and per-cell contents.
  logic [31:0]        map_key [SLOTS];
  bit                 map_valid [SLOTS];
  int                 map_used;
  logic signed [15:0] map_height [CELLS];
  logic [7:0]         map_conf [CELLS];

  map_cmd_t     pending_cmds[$];
  cell_result_t expected_cells[$];
  int           errors = 0;

  // Apply one command to the shadow map and return the result it gives.
  function automatic cell_result_t apply_map_cmd(map_cmd_t c);
    cell_result_t r;
    logic [31:0] key;
    int off, slot, base, cur_h, new_h, cur_c, new_c;
    bit wr;
    key = {c.x[20:BLK_SHIFT], c.y[20:BLK_SHIFT]};
    off = int'({c.x[BLK_SHIFT-1:0], c.y[BLK_SHIFT-1:0]});
    r = '{h: '0, conf: '0, found: 1'b0, full: 1'b0};
    if (c.cmd == CMD_CLEAR) begin
      foreach (map_valid[i]) map_valid[i] = 0;
      map_used = 0;
      return r;
    end
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && map_valid[i] && map_key[i] == key) slot = i;
    r.found = (slot >= 0);
    cur_h = 0;
    cur_c = 0;
    if (slot >= 0) begin
      cur_h = int'(map_height[slot*1024 + off]);
      cur_c = int'(map_conf[slot*1024 + off]);
    end
    new_h = cur_h;
    new_c = cur_c;
    wr = 0;
    case (c.cmd)
      CMD_SET: begin
        new_h = int'(c.h); new_c = int'(c.sc); wr = 1;
      end
      CMD_RAISE: begin
        wr = 1;
        if (cur_c == 0) begin
          new_h = int'(c.h); new_c = 1;
        end else begin
          new_h = (int'(c.h) > cur_h) ? int'(c.h) : cur_h;
          new_c = (cur_c + 1 < int'(CONF_CAP)) ? cur_c + 1 : int'(CONF_CAP);
        end
      end
      CMD_LOWER: begin
        if (cur_c != 0 && cur_h + int'(FUSE_MARGIN_MM) > int'(c.h)) begin
          wr = 1;
          if (cur_c < int'(CONF_CAP)) begin
            new_h = int'(c.h); new_c = int'(CONF_CAP);
          end else begin
            new_c = (cur_c - 1 > 1) ? cur_c - 1 : 1;
          end
        end
      end
      default: ;
    endcase
    if (wr) begin
      if (slot < 0 && map_used < SLOTS) begin
        slot = map_used;
        map_used++;
        map_valid[slot] = 1;
        map_key[slot] = key;
        base = slot * 1024;
        for (int i = 0; i < 1024; i++) begin
          map_height[base + i] = '0;
          map_conf[base + i] = '0;
        end
      end
      if (slot < 0) begin
        r.full = 1'b1; new_h = 0; new_c = 0;
      end else begin
        map_height[slot*1024 + off] = 16'(new_h);
        map_conf[slot*1024 + off] = 8'(new_c);
      end
    end
    r.h = 16'(new_h);
    r.conf = 8'(new_c);
    return r;
  endfunction

  function automatic map_cmd_t mk(logic [2:0] cmd, logic signed [20:0] x,
                                  logic signed [20:0] y, logic signed [15:0] h,
                                  logic [7:0] sc);
    mk = '{cmd: cmd, x: x, y: y, h: h, sc: sc, drain: (cmd == CMD_CLEAR)};
  endfunction

  // Driver: present queued commands with random gaps; hold drain beats.
  int       src_gap = 0;
  bit       src_burst = 0;
  int       src_count = 0;
  map_cmd_t src_cur;
  always @(posedge clk) begin
    logic v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      v = in_tvalid;
      if (v && in_tready) begin
        expected_cells.push_back(apply_map_cmd(src_cur));
        v = 1'b0;
        src_count++;
        if (src_count % 40 == 0) src_burst = ($urandom_range(0, 2) == 0);
        src_gap = src_burst ? 0 : $urandom_range(0, 5);
      end
      if (!v) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_cells.size() > 0)) begin
          src_cur = pending_cmds.pop_front();
          in_tdata <= {6'b0, src_cur.sc, src_cur.h, src_cur.y, src_cur.x};
          in_tuser <= src_cur.cmd;
          v = 1'b1;
        end
      end
      in_tvalid <= v;
    end
  end

  // Monitor: stall at random, compare each result beat with the oldest expectation.
  int  snk_stall = 0;
  int  snk_count = 0;
  bit  snk_burst = 0;
  always @(posedge clk) begin
    cell_result_t e;
    logic r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      r = out_tready;
      if (out_tvalid && out_tready) begin
        if (expected_cells.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          e = expected_cells.pop_front();
          if (out_tdata[15:0] !== e.h) begin
            $error("cell_height exp %0d got %0d", e.h, $signed(out_tdata[15:0]));
            errors++;
          end
          if (out_tdata[23:16] !== e.conf) begin
            $error("cell_confidence exp %0d got %0d", e.conf, out_tdata[23:16]);
            errors++;
          end
          if (out_tuser[0] !== e.found) begin
            $error("block_found exp %0b got %0b", e.found, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== e.full) begin
            $error("table_full exp %0b got %0b", e.full, out_tuser[1]);
            errors++;
          end
        end
        snk_count++;
        if (snk_count % 50 == 0) snk_burst = ($urandom_range(0, 2) == 0);
        snk_stall = snk_burst ? 0 : $urandom_range(0, 5);
        r = (snk_stall == 0);
      end else if (!r) begin
        if (snk_stall > 0) snk_stall--;
        r = (snk_stall == 0);
      end
      out_tready <= r;
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random cell inside block (bx, by); offsets stay small most of the time
  // so that cells get hit repeatedly.
  function automatic logic signed [20:0] cell_in(logic [15:0] b);
    logic [4:0] o;
    o = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 2));
    return {b, o};
  endfunction

  initial begin
    logic [15:0] pool_x [$];
    logic [15:0] pool_y [$];
    logic [2:0]  cmd;
    logic signed [15:0] base_h, h;
    int nblk, nops, k, pick;

    // Directed part.
    pending_cmds.push_back(mk(CMD_READ, -21'sd1048576, 21'sd1048575, 0, 0));
    pending_cmds.push_back(mk(CMD_LOWER, 21'sd5, 21'sd5, -16'sd32768, 0));
    pending_cmds.push_back(mk(CMD_READ, 21'sd5, 21'sd5, 0, 0));
    pending_cmds.push_back(mk(CMD_SET, 21'sd1048575, -21'sd1048576, 16'sd32767, 8'd255));
    pending_cmds.push_back(mk(CMD_READ, 21'sd1048575, -21'sd1048576, 0, 0));
    pending_cmds.push_back(mk(CMD_RAISE, 21'sd1048575, -21'sd1048576, -16'sd32768, 0));
    pending_cmds.push_back(mk(CMD_RAISE, -21'sd1, -21'sd32, 16'sd200, 0));
    pending_cmds.push_back(mk(CMD_RAISE, -21'sd1, -21'sd32, 16'sd100, 0));
    pending_cmds.push_back(mk(CMD_RAISE, -21'sd1, -21'sd32, 16'sd300, 0));
    pending_cmds.push_back(mk(CMD_LOWER, -21'sd1, -21'sd32, 16'sd1250, 0));
    pending_cmds.push_back(mk(CMD_LOWER, -21'sd1, -21'sd32, 16'sd900, 0));
    pending_cmds.push_back(mk(CMD_LOWER, -21'sd1, -21'sd32, 16'sd900, 0));
    pending_cmds.push_back(mk(CMD_LOWER, -21'sd1, -21'sd32, 16'sd1900, 0));
    pending_cmds.push_back(mk(CMD_SET, 21'sd33, 21'sd0, -16'sd5, 8'd0));
    pending_cmds.push_back(mk(CMD_LOWER, 21'sd33, 21'sd0, -16'sd500, 0));
    pending_cmds.push_back(mk(CMD_RAISE, 21'sd33, 21'sd0, -16'sd700, 0));
    pending_cmds.push_back(mk(CMD_SPARE_5, -21'sd1, -21'sd32, 0, 0));
    pending_cmds.push_back(mk(CMD_SPARE_6, 21'sd33, 21'sd0, 0, 0));
    pending_cmds.push_back(mk(CMD_SPARE_7, 21'sd7, 21'sd7, 16'sd1, 8'd1));
    pending_cmds.push_back(mk(CMD_CLEAR, 21'sd0, 21'sd0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, -21'sd1, -21'sd32, 0, 0));
    pending_cmds.push_back(mk(CMD_SET, -21'sd1, -21'sd32, -16'sd1, 8'd4));
    pending_cmds.push_back(mk(CMD_READ, -21'sd1, -21'sd32, 0, 0));

    // Random episodes: a block pool, mixed commands on it, then a clear.
    // Pools larger than the slot table drive the table-full path.
    k = 0;
    while (k < 600) begin
      pool_x.delete();
      pool_y.delete();
      nblk = ($urandom_range(0, 2) == 0) ? $urandom_range(66, 80) : $urandom_range(2, 12);
      nops = (nblk > 64) ? 110 : $urandom_range(40, 70);
      for (int i = 0; i < nblk; i++) begin
        case ($urandom_range(0, 5))
          0: pool_x.push_back(16'h8000);
          1: pool_x.push_back(16'h7fff);
          default: pool_x.push_back(16'($urandom));
        endcase
        pool_y.push_back((i % 7 == 3) ? 16'hffff : 16'($urandom));
      end
      base_h = 16'($urandom_range(0, 20000)) - 16'sd10000;
      for (int i = 0; i < nops; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 22) cmd = CMD_SET;
        else if (pick < 52) cmd = CMD_RAISE;
        else if (pick < 77) cmd = CMD_LOWER;
        else if (pick < 96) cmd = CMD_READ;
        else cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        if ($urandom_range(0, 9) == 0) h = 16'($urandom);
        else h = base_h + 16'($urandom_range(0, 3000)) - 16'sd1500;
        pick = (nblk > 64) ? i % nblk : $urandom_range(0, nblk - 1);
        if ($urandom_range(0, 19) == 0)
          pending_cmds.push_back(mk(cmd, 21'($urandom), 21'($urandom), h, 8'($urandom)));
        else
          pending_cmds.push_back(mk(cmd, cell_in(pool_x[pick]), cell_in(pool_y[pick]), h,
                                    ($urandom_range(0, 1) ? 8'($urandom) :
                                     8'($urandom_range(0, 5)))));
      end
      pending_cmds.push_back(mk(CMD_CLEAR, 21'($urandom), 21'($urandom), 0, 0));
      k += nops + 1;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Poll once a cycle until the queue is empty and every result is back.
    while (pending_cmds.size() != 0 || in_tvalid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+src
src/sbhm_pkg.sv
src/sbhm_slot_tab.sv
src/sbhm_cell_ram.sv
src/sparse_block_height_map.sv
tb/sparse_block_height_map_tb.sv
